// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the ledger resolver.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock, muted in reset
`define CLR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/core/clr_pkg.sv
// ----------------------------------------------------------------------------
// clr_pkg
// Shared types and constants of the constraint ledger resolver.
// ----------------------------------------------------------------------------
`default_nettype none
package clr_pkg;
    localparam int SlotsDefault = 16;

    localparam logic [1:0] KIND_ASSERT      = 2'd0;
    localparam logic [1:0] KIND_RETRACT     = 2'd1;
    localparam logic [1:0] KIND_RETRACT_ALL = 2'd2;
    localparam logic [1:0] KIND_BASELINE    = 2'd3;

    localparam logic [1:0] OP_FORCE = 2'd0;
    localparam logic [1:0] OP_CAP   = 2'd1;
    localparam logic [1:0] OP_FLOOR = 2'd2;
    // stored and counted for reasons, ignored by the resolve
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_SRC0 = 2'd2;

    localparam logic [1:0] ACT_BASELINE = 2'd0;
    localparam logic [1:0] ACT_ASSERT   = 2'd1;
    localparam logic [1:0] ACT_RETRACT  = 2'd2;

    // one stored constraint: 130 bits
    typedef struct packed {
        logic [31:0] reasons;
        logic [31:0] stamp;
        logic [15:0] prio;
        logic [31:0] value;
        logic [1:0]  op;
        logic [15:0] source;
    } t_slot;

    localparam int SlotW = $bits(t_slot);
endpackage
`default_nettype wire

// File: rtl/core/clr_ram.sv
// ----------------------------------------------------------------------------
// clr_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module clr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire logic [WIDTH-1:0]     i_wdata,
    input  wire logic [AW-1:0]        i_raddr,
    output      logic [WIDTH-1:0]     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/constraint_ledger_resolver.sv
// ----------------------------------------------------------------------------
// constraint_ledger_resolver
// Each item passes through a lookup sweep of the slots, an apply step, a resolve
// sweep, an emit step and a park step before its result reaches the output.
// The block takes no new item while one is in flight; the next item is
// accepted once the result, if one is produced, is parked in the output register.
// Reset (synchronous, active low) clears valid bits, baseline, effective value
// and binding tag; the slot RAM needs no clearing since valid bits guard it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module constraint_ledger_resolver #(
    parameter int SLOTS = clr_pkg::SlotsDefault
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output      logic         s_axis_tready,
    // kind[1:0], source_id[17:2], op[19:18], value[51:20], priority_req[67:52],
    // stamp[99:68], reasons[131:100], zero fill up to 136
    input  wire logic [135:0] s_axis_tdata,
    output      logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[1:0], action[3:2], cause_source[19:4], old_effective[51:20],
    // new_effective[83:52], record_stamp[115:84], binding_source[131:116],
    // changed[132], active_reasons[164:133], zero fill up to 168
    output      logic [167:0] m_axis_tdata
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1) + 1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOOK   = 6'b000010,
        S_APPLY  = 6'b000100,
        S_RES    = 6'b001000,
        S_EMIT   = 6'b010000,
        S_WAIT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // captured item
    logic [1:0]  r_kind;
    logic [15:0] r_src;
    logic [1:0]  r_op;
    logic [31:0] r_val, r_stamp, r_rsn;
    logic [15:0] r_prio;

    logic [SLOTS-1:0] r_valid;
    logic [31:0] r_base, r_eff;
    logic [15:0] r_bind;

    // sweep control: r_cnt issues addresses, r_pend marks data from previous read
    logic [CW-1:0] r_cnt;
    logic          r_pend;
    logic [AW-1:0] r_pidx;

    // lookup results
    logic          r_hit, r_free_ok;
    logic [AW-1:0] r_hit_idx, r_free_idx;

    // resolve accumulators
    logic          r_fany;
    logic [15:0]   r_fprio;
    logic [31:0]   r_fstamp, r_fval, r_cval, r_lval;
    logic [15:0]   r_fsrc, r_csrc, r_lsrc;
    logic          r_lany;
    logic [31:0]   r_ror;
    logic [31:0]   r_old;

    // output register
    logic          r_ovalid;
    logic [167:0]  r_odata;

    // record fields decided from the captured item and lookup
    logic        emit_ok;
    logic [1:0]  o_status, o_action;
    logic [15:0] o_cause;

    // emptiness and baseline change, captured at the apply step
    logic r_all_empty, r_base_chg;

    // RAM
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    clr_pkg::t_slot    ram_wdata, ram_rdata;

    clr_ram #(.WIDTH(clr_pkg::SlotW), .DEPTH(SLOTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign ram_raddr     = r_cnt[AW-1:0];

    logic slot_dest;
    logic [AW-1:0] dest_idx;
    always_comb begin
        slot_dest = r_hit | r_free_ok;
        dest_idx  = r_hit ? r_hit_idx : r_free_idx;
        ram_we    = (r_state == S_APPLY) && (r_kind == clr_pkg::KIND_ASSERT)
                    && (r_src != 16'd0) && slot_dest;
        ram_waddr = dest_idx;
        ram_wdata = '{reasons: r_rsn, stamp: r_stamp, prio: r_prio, value: r_val,
                      op: r_op, source: r_src};
    end

    wire sweep_done = (r_cnt >= CW'(SLOTS));
    wire pv         = r_pend && r_valid[r_pidx];

    // resolved value once the sweep ends
    logic [31:0] res_eff;
    logic [15:0] res_bind;
    always_comb begin
        if (r_fany) begin
            res_eff  = r_fval;
            res_bind = r_fsrc;
        end else if (r_lany) begin
            res_eff  = r_lval;
            res_bind = r_lsrc;
        end else begin
            res_eff  = r_cval;
            res_bind = r_csrc;
        end
    end

    always_comb begin
        emit_ok  = 1'b1;
        o_status = clr_pkg::ST_OK;
        o_action = clr_pkg::ACT_ASSERT;
        o_cause  = r_src;
        case (r_kind)
            clr_pkg::KIND_ASSERT: begin
                if (r_src == 16'd0) begin
                    o_status = clr_pkg::ST_SRC0;
                end else if (!r_hit && !r_free_ok) begin
                    o_status = clr_pkg::ST_FULL;
                end
            end
            clr_pkg::KIND_RETRACT: begin
                o_action = clr_pkg::ACT_RETRACT;
                emit_ok  = r_hit;
            end
            clr_pkg::KIND_RETRACT_ALL: begin
                o_action = clr_pkg::ACT_RETRACT;
                o_cause  = '0;
                emit_ok  = !r_all_empty;
            end
            clr_pkg::KIND_BASELINE: begin
                o_action = clr_pkg::ACT_BASELINE;
                o_cause  = '0;
                emit_ok  = r_base_chg;
            end
            default: emit_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (s_axis_tvalid) n_state = S_LOOK;
            S_LOOK:  if (sweep_done && !r_pend) n_state = S_APPLY;
            S_APPLY: n_state = S_RES;
            S_RES:   if (sweep_done && !r_pend) n_state = S_EMIT;
            S_EMIT:  n_state = S_WAIT;
            S_WAIT:  if (!r_ovalid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_base   <= '0;
            r_eff    <= '0;
            r_bind   <= '0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_pend   <= 1'b0;
        end else begin
            r_state <= n_state;
            // park the record once the output register is free, else drain it
            if (r_state == S_WAIT && (!r_ovalid || m_axis_tready) && emit_ok) begin
                r_ovalid <= 1'b1;
                r_odata  <= {3'd0, r_ror, (r_old != r_eff), r_bind, r_stamp,
                             r_eff, r_old, o_cause, o_action, o_status};
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_kind    <= s_axis_tdata[1:0];
                        r_src     <= s_axis_tdata[17:2];
                        r_op      <= s_axis_tdata[19:18];
                        r_val     <= s_axis_tdata[51:20];
                        r_prio    <= s_axis_tdata[67:52];
                        r_stamp   <= s_axis_tdata[99:68];
                        r_rsn     <= s_axis_tdata[131:100];
                        r_old     <= r_eff;
                        r_cnt     <= '0;
                        r_pend    <= 1'b0;
                        r_hit     <= 1'b0;
                        r_free_ok <= 1'b0;
                    end
                end
                S_LOOK: begin
                    // free slot search needs no RAM data
                    if (!sweep_done) begin
                        r_pend <= 1'b1;
                        r_pidx <= r_cnt[AW-1:0];
                        r_cnt  <= r_cnt + 1'b1;
                        if (!r_free_ok && !r_valid[r_cnt[AW-1:0]]) begin
                            r_free_ok  <= 1'b1;
                            r_free_idx <= r_cnt[AW-1:0];
                        end
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (pv && !r_hit && ram_rdata.source == r_src) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_pidx;
                    end
                end
                S_APPLY: begin
                    r_cnt  <= '0;
                    r_pend <= 1'b0;
                    r_fany <= 1'b0;
                    r_lany <= 1'b0;
                    r_ror  <= '0;
                    r_csrc <= '0;
                    case (r_kind)
                        clr_pkg::KIND_ASSERT: begin
                            if (r_src != 16'd0 && slot_dest) r_valid[dest_idx] <= 1'b1;
                            r_cval <= r_base;
                        end
                        clr_pkg::KIND_RETRACT: begin
                            if (r_hit) r_valid[r_hit_idx] <= 1'b0;
                            r_cval <= r_base;
                        end
                        clr_pkg::KIND_RETRACT_ALL: begin
                            r_valid <= '0;
                            r_cval  <= r_base;
                        end
                        clr_pkg::KIND_BASELINE: begin
                            if (r_val != r_base) r_base <= r_val;
                            r_cval <= r_val;
                        end
                        default: r_cval <= r_base;
                    endcase
                end
                S_RES: begin
                    if (!sweep_done) begin
                        r_pend <= 1'b1;
                        r_pidx <= r_cnt[AW-1:0];
                        r_cnt  <= r_cnt + 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (pv) begin
                        r_ror <= r_ror | ram_rdata.reasons;
                        case (ram_rdata.op)
                            clr_pkg::OP_FORCE: begin
                                if (!r_fany || $signed(ram_rdata.prio) > $signed(r_fprio)
                                    || (ram_rdata.prio == r_fprio
                                        && ram_rdata.stamp > r_fstamp)) begin
                                    r_fany   <= 1'b1;
                                    r_fprio  <= ram_rdata.prio;
                                    r_fstamp <= ram_rdata.stamp;
                                    r_fval   <= ram_rdata.value;
                                    r_fsrc   <= ram_rdata.source;
                                end
                            end
                            clr_pkg::OP_CAP: begin
                                if ($signed(ram_rdata.value) < $signed(r_cval)) begin
                                    r_cval <= ram_rdata.value;
                                    r_csrc <= ram_rdata.source;
                                end
                            end
                            clr_pkg::OP_FLOOR: begin
                                // floors are judged against the final cap result,
                                // so keep the largest floor and compare at the end
                                if (!r_lany || $signed(ram_rdata.value) > $signed(r_lval))
                                begin
                                    r_lany <= 1'b1;
                                    r_lval <= ram_rdata.value;
                                    r_lsrc <= ram_rdata.source;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_EMIT: begin
                    // drop the floor unless it lies strictly above the capped value
                    if (r_fany || !r_lany || $signed(r_lval) > $signed(r_cval)) begin
                        r_eff  <= res_eff;
                        r_bind <= res_bind;
                    end else begin
                        r_eff  <= r_cval;
                        r_bind <= r_csrc;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_APPLY) begin
            r_all_empty <= (r_valid == '0);
            r_base_chg  <= (r_val != r_base);
        end
    end

    `CLR_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !s_axis_tready,
        "input accepted while busy")
    `CLR_ASSERT_NEXT(a_ram_write_once, i_clk, i_rst_n, ram_we, r_state == S_RES,
        "slot write outside apply step")
    `CLR_ASSERT_IMP(a_src0_no_write, i_clk, i_rst_n, ram_we, r_src != 16'd0,
        "slot written for source zero")
endmodule
`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the constraint ledger resolver: a directed table of
// corner items, then random well-formed sessions, checked against a local
// model of the constraint table under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam int NSLOT = clr_pkg::SlotsDefault;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] src;
        logic [1:0]  op;
        logic [31:0] value;
        logic [15:0] prio;
        logic [31:0] stamp;
        logic [31:0] reasons;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  action;
        logic [15:0] cause;
        logic [31:0] old_eff;
        logic [31:0] new_eff;
        logic [31:0] stamp;
        logic [15:0] binding;
        logic        changed;
        logic [31:0] reasons;
    } t_rec;

    typedef struct {
        t_cmd cmd;
        bit   typed;     // expected record written into the table
        t_rec rec;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [167:0] m_axis_tdata;

    constraint_ledger_resolver uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ledger model state
    bit          led_valid [NSLOT];
    logic [15:0] led_src   [NSLOT];
    logic [1:0]  led_op    [NSLOT];
    logic [31:0] led_val   [NSLOT];
    logic [15:0] led_prio  [NSLOT];
    logic [31:0] led_stamp [NSLOT];
    logic [31:0] led_rsn   [NSLOT];
    logic [31:0] led_base, led_eff;
    logic [15:0] led_bind;

    t_rec records_due[$];
    int   fails = 0;
    int   send_gap_pct = 0;
    int   stall_pct = 0;
    bit   hold_off = 1'b0;
    logic [15:0] src_pool [8];

    function automatic void resolve_ledger();
        int win = -1;
        logic signed [31:0] eff;
        logic [15:0] bsrc;
        for (int i = 0; i < NSLOT; i++) begin
            if (led_valid[i] && led_op[i] == clr_pkg::OP_FORCE) begin
                if (win < 0 || $signed(led_prio[i]) > $signed(led_prio[win]) ||
                    (led_prio[i] == led_prio[win] && led_stamp[i] > led_stamp[win]))
                    win = i;
            end
        end
        if (win >= 0) begin
            led_eff = led_val[win];
            led_bind = led_src[win];
            return;
        end
        eff = led_base;
        bsrc = '0;
        for (int i = 0; i < NSLOT; i++)
            if (led_valid[i] && led_op[i] == clr_pkg::OP_CAP
                && $signed(led_val[i]) < eff) begin
                eff = led_val[i];
                bsrc = led_src[i];
            end
        for (int i = 0; i < NSLOT; i++)
            if (led_valid[i] && led_op[i] == clr_pkg::OP_FLOOR
                && $signed(led_val[i]) > eff) begin
                eff = led_val[i];
                bsrc = led_src[i];
            end
        led_eff = eff;
        led_bind = bsrc;
    endfunction

    // apply one command to the ledger; returns 1 when a record is produced
    function automatic bit apply_ledger(input t_cmd c, output t_rec r);
        logic [31:0] old = led_eff;
        int s = -1;
        bit any = 1'b0;
        logic [1:0] st = clr_pkg::ST_OK;
        logic [1:0] act = clr_pkg::ACT_ASSERT;
        logic [15:0] cause = c.src;
        for (int i = 0; i < NSLOT; i++)
            if (led_valid[i] && led_src[i] == c.src && s < 0) s = i;
        case (c.kind)
            clr_pkg::KIND_ASSERT: begin
                if (c.src == 0) begin
                    st = clr_pkg::ST_SRC0;
                    cause = '0;
                end else begin
                    if (s < 0)
                        for (int i = NSLOT - 1; i >= 0; i--)
                            if (!led_valid[i]) s = i;
                    if (s < 0) st = clr_pkg::ST_FULL;
                    else begin
                        led_valid[s] = 1'b1;
                        led_src[s] = c.src;
                        led_op[s] = c.op;
                        led_val[s] = c.value;
                        led_prio[s] = c.prio;
                        led_stamp[s] = c.stamp;
                        led_rsn[s] = c.reasons;
                        resolve_ledger();
                    end
                end
            end
            clr_pkg::KIND_RETRACT: begin
                if (s < 0) return 1'b0;
                act = clr_pkg::ACT_RETRACT;
                led_valid[s] = 1'b0;
                resolve_ledger();
            end
            clr_pkg::KIND_RETRACT_ALL: begin
                foreach (led_valid[i]) any |= led_valid[i];
                if (!any) return 1'b0;
                act = clr_pkg::ACT_RETRACT;
                cause = '0;
                foreach (led_valid[i]) led_valid[i] = 1'b0;
                resolve_ledger();
            end
            default: begin
                if (c.value == led_base) return 1'b0;
                act = clr_pkg::ACT_BASELINE;
                cause = '0;
                led_base = c.value;
                resolve_ledger();
            end
        endcase
        r.status = st;
        r.action = act;
        r.cause = cause;
        r.old_eff = old;
        r.new_eff = led_eff;
        r.stamp = c.stamp;
        r.binding = led_bind;
        r.changed = (old != led_eff);
        r.reasons = '0;
        for (int i = 0; i < NSLOT; i++)
            if (led_valid[i]) r.reasons |= led_rsn[i];
        return 1'b1;
    endfunction

    function automatic t_cmd mk(input logic [1:0] k, input logic [15:0] s,
                                input logic [1:0] o, input logic [31:0] v,
                                input logic [15:0] p, input logic [31:0] t,
                                input logic [31:0] rs);
        t_cmd c;
        c.kind = k; c.src = s; c.op = o; c.value = v;
        c.prio = p; c.stamp = t; c.reasons = rs;
        return c;
    endfunction

    function automatic t_rec rec(input logic [1:0] st, input logic [1:0] a,
                                 input logic [15:0] cs, input logic [31:0] oe,
                                 input logic [31:0] ne, input logic [31:0] t,
                                 input logic [15:0] b, input logic [31:0] rs);
        t_rec r;
        r.status = st; r.action = a; r.cause = cs; r.old_eff = oe; r.new_eff = ne;
        r.stamp = t; r.binding = b; r.changed = (oe != ne); r.reasons = rs;
        return r;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int pick = $urandom_range(99);
        c = mk(clr_pkg::KIND_ASSERT, src_pool[$urandom_range(7)], 2'($urandom_range(2)),
               $urandom, 16'($urandom_range(6)) - 16'd3, $urandom_range(5),
               32'd1 << $urandom_range(31));
        // mostly small values so that caps and floors interleave with the baseline
        if ($urandom_range(3) != 0) c.value = 32'($signed($urandom_range(200)) - 100);
        if ($urandom_range(7) == 0) c.prio = 16'($urandom);
        if ($urandom_range(7) == 0) c.stamp = $urandom;
        if ($urandom_range(3) == 0) c.reasons = $urandom;
        if (pick < 5) c.src = 16'($urandom);
        else if (pick < 7) c.src = '0;
        else if (pick < 9) c.op = clr_pkg::OP_SPARE;
        else if (pick < 25) c.kind = clr_pkg::KIND_RETRACT;
        else if (pick < 28) c.kind = clr_pkg::KIND_RETRACT_ALL;
        else if (pick < 38) c.kind = clr_pkg::KIND_BASELINE;
        return c;
    endfunction

    // offer one transfer and wait for its acceptance; valid stays high for the next
    task automatic offer(input t_cmd c);
        t_rec r;
        if ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        s_axis_tdata <= {4'b0, c.reasons, c.stamp, c.prio, c.value, c.op, c.src, c.kind};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (apply_ledger(c, r)) records_due.push_back(r);
    endtask

    // send a row whose expected record is given by hand (ledger already updated)
    task automatic offer_typed(input t_cmd c, input t_rec exp_r);
        s_axis_tdata <= {4'b0, c.reasons, c.stamp, c.prio, c.value, c.op, c.src, c.kind};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        records_due.push_back(exp_r);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (records_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // sink: random stalls, plus a long hold-off when requested
    always @(posedge i_clk) begin
        m_axis_tready <= i_rst_n && !hold_off && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_rec act, exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            act.status  = m_axis_tdata[1:0];
            act.action  = m_axis_tdata[3:2];
            act.cause   = m_axis_tdata[19:4];
            act.old_eff = m_axis_tdata[51:20];
            act.new_eff = m_axis_tdata[83:52];
            act.stamp   = m_axis_tdata[115:84];
            act.binding = m_axis_tdata[131:116];
            act.changed = m_axis_tdata[132];
            act.reasons = m_axis_tdata[164:133];
            if (records_due.size() == 0) begin
                $display("%0t: unexpected record %h", $time, act);
                fails++;
            end else begin
                exp_r = records_due.pop_front();
                if (act !== exp_r) begin
                    $display("%0t: record mismatch expected %h actual %h",
                             $time, exp_r, act);
                    fails++;
                end
            end
        end
    end

    t_row dir[$];

    initial begin
        t_row row;
        t_rec r;
        t_cmd c;
        foreach (led_valid[i]) led_valid[i] = 1'b0;
        led_base = '0; led_eff = '0; led_bind = '0;
        foreach (src_pool[i]) src_pool[i] = 16'(i + 1);
        src_pool[7] = 16'hFFFF;

        // directed rows: typed expectations where obvious, else predicted
        dir.push_back('{mk(clr_pkg::KIND_ASSERT, 16'd0, clr_pkg::OP_FORCE, 32'd5, 16'd0,
                           32'd7, 32'h1), 1,
                        rec(clr_pkg::ST_SRC0, clr_pkg::ACT_ASSERT, 16'd0, 0, 0, 32'd7,
                            16'd0, 0)});
        dir.push_back('{mk(clr_pkg::KIND_RETRACT, 16'd9, clr_pkg::OP_FORCE, 0, 0, 0, 0),
                        0, r});
        dir.push_back('{mk(clr_pkg::KIND_RETRACT_ALL, 16'd0, clr_pkg::OP_FORCE, 0, 0, 0, 0),
                        0, r});
        dir.push_back('{mk(clr_pkg::KIND_BASELINE, 16'd0, clr_pkg::OP_FORCE, 32'd0, 0, 0, 0),
                        0, r});
        dir.push_back('{mk(clr_pkg::KIND_BASELINE, 16'd0, clr_pkg::OP_FORCE, 32'h7FFF_FFFF,
                           16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1,
                        rec(clr_pkg::ST_OK, clr_pkg::ACT_BASELINE, 0, 0, 32'h7FFF_FFFF,
                            32'hFFFF_FFFF, 0, 0)});
        dir.push_back('{mk(clr_pkg::KIND_ASSERT, 16'hFFFF, clr_pkg::OP_CAP, 32'h8000_0000,
                           16'h8000, 32'd1, 32'h8000_0000), 1,
                        rec(clr_pkg::ST_OK, clr_pkg::ACT_ASSERT, 16'hFFFF, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'd1, 16'hFFFF, 32'h8000_0000)});
        dir.push_back('{mk(clr_pkg::KIND_ASSERT, 16'd2, clr_pkg::OP_FLOOR, 32'd10, 0,
                           32'd2, 32'h1), 0, r});
        dir.push_back('{mk(clr_pkg::KIND_ASSERT, 16'd3, clr_pkg::OP_FLOOR, 32'd10, 0,
                           32'd3, 32'h2), 0, r});
        dir.push_back('{mk(clr_pkg::KIND_ASSERT, 16'd4, clr_pkg::OP_SPARE, 32'd99, 0,
                           32'd4, 32'h4), 0, r});
        dir.push_back('{mk(clr_pkg::KIND_ASSERT, 16'd5, clr_pkg::OP_FORCE, 32'd50, 16'h7FFF,
                           32'd9, 32'h8), 0, r});
        dir.push_back('{mk(clr_pkg::KIND_ASSERT, 16'd6, clr_pkg::OP_FORCE, 32'd60, 16'h7FFF,
                           32'd9, 32'h10), 0, r});
        dir.push_back('{mk(clr_pkg::KIND_ASSERT, 16'd7, clr_pkg::OP_FORCE, 32'd70, 16'h7FFF,
                           32'd10, 32'h20), 0, r});
        dir.push_back('{mk(clr_pkg::KIND_ASSERT, 16'd7, clr_pkg::OP_FORCE, 32'd70, 16'h7FFF,
                           32'd10, 32'h20), 0, r});
        dir.push_back('{mk(clr_pkg::KIND_RETRACT, 16'd7, clr_pkg::OP_FORCE, 0, 0, 32'd11, 0),
                        0, r});
        for (int i = 0; i < 11; i++)
            dir.push_back('{mk(clr_pkg::KIND_ASSERT, 16'(100 + i), clr_pkg::OP_CAP, 32'(i),
                               16'(i), 32'(i), 32'(1 << i)), 0, r});
        dir.push_back('{mk(clr_pkg::KIND_ASSERT, 16'hABCD, clr_pkg::OP_FLOOR, 0, 0,
                           32'd20, 0), 0, r});
        dir.push_back('{mk(clr_pkg::KIND_RETRACT_ALL, 16'd0, clr_pkg::OP_FORCE, 0, 0,
                           32'd21, 0), 0, r});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir[i]) begin
            row = dir[i];
            if (row.typed) begin
                // override the predictor with the hand-written record
                c = row.cmd;
                void'(apply_ledger(c, r));
                offer_typed(c, row.rec);
            end else begin
                offer(row.cmd);
            end
        end
        drain();

        // random phases: free flow behind a long sink hold-off, slow sender, slow sink, both slow
        for (int ph = 0; ph < 4; ph++) begin
            send_gap_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 58 : 17) : 0;
            stall_pct    = (ph == 2 || ph == 3) ? ((ph == 2) ? 58 : 17) : 0;
            if (ph == 0) fork
                begin
                    hold_off = 1'b1;
                    repeat (400) @(posedge i_clk);
                    hold_off = 1'b0;
                end
            join_none
            for (int n = 0; n < 410; n++) begin
                if ($urandom_range(49) == 0)
                    foreach (src_pool[i]) src_pool[i] = 16'($urandom_range(1, 40));
                offer(random_cmd());
            end
            drain();
        end

        if (fails == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire
